// File: hw/rtl/dhru_pkg.sv
// Shared types and constants of the digitizer hit record unpacker.
// Used by the interfaces, the register block and the unpack datapath.
package dhru_pkg;

   localparam int unsigned DATA_W    = 8;
   localparam int unsigned PHASE_W   = 6;
   localparam int unsigned NUM_SEG   = 9;
   localparam int unsigned SEG_IDX_W = 4;
   localparam int unsigned SEG_LEN_W = 4;
   localparam int unsigned CSR_AW    = 4;
   localparam int unsigned CSR_DW    = 32;

   localparam logic [PHASE_W-1:0] PH_SAMPLE_LO = 6'd62;
   localparam logic [PHASE_W-1:0] PH_SAMPLE_HI = 6'd63;

   localparam logic [SEG_IDX_W-1:0] SEG_BOARD    = 4'd0;
   localparam logic [SEG_IDX_W-1:0] SEG_CHANNEL  = 4'd1;
   localparam logic [SEG_IDX_W-1:0] SEG_TIME     = 4'd2;
   localparam logic [SEG_IDX_W-1:0] SEG_ENERGY   = 4'd3;
   localparam logic [SEG_IDX_W-1:0] SEG_ECAL     = 4'd4;
   localparam logic [SEG_IDX_W-1:0] SEG_ESHORT   = 4'd5;
   localparam logic [SEG_IDX_W-1:0] SEG_FLAGS    = 4'd6;
   localparam logic [SEG_IDX_W-1:0] SEG_WAVECODE = 4'd7;
   localparam logic [SEG_IDX_W-1:0] SEG_COUNT    = 4'd8;

   localparam logic [SEG_LEN_W-1:0] SEG_LEN [NUM_SEG] =
      '{4'd2, 4'd2, 4'd8, 4'd2, 4'd8, 4'd2, 4'd4, 4'd1, 4'd4};

   localparam logic [1:0] REG_HAS_ENERGY   = 2'd0;
   localparam logic [1:0] REG_HAS_ECAL     = 2'd1;
   localparam logic [1:0] REG_HAS_ESHORT   = 2'd2;
   localparam logic [1:0] REG_HAS_WAVEFORM = 2'd3;

   localparam logic KIND_RECORD = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   typedef struct packed {
      logic has_energy;
      logic has_energy_calibrated;
      logic has_energy_short;
      logic has_waveform;
   } cfg_type;

   typedef struct packed {
      logic        item_kind;
      logic [15:0] board_id;
      logic [15:0] channel_id;
      logic [63:0] time_tag;
      logic [15:0] energy_long;
      logic [63:0] energy_cal_bits;
      logic [15:0] energy_short_gate;
      logic [31:0] hit_flags;
      logic [7:0]  wave_code;
      logic [31:0] sample_total;
      logic [15:0] sample_value;
      logic        end_of_hit;
   } rsp_type;

endpackage

// File: hw/rtl/dhru_if.sv
// Valid/ready channel interfaces of the hit record unpacker.
// Depends on dhru_pkg for widths.
interface dhru_req_if;
   logic                        valid;
   logic                        ready;
   logic [dhru_pkg::DATA_W-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface dhru_rsp_if;
   logic        valid;
   logic        ready;
   logic        item_kind;
   logic [15:0] board_id;
   logic [15:0] channel_id;
   logic [63:0] time_tag;
   logic [15:0] energy_long;
   logic [63:0] energy_cal_bits;
   logic [15:0] energy_short_gate;
   logic [31:0] hit_flags;
   logic [7:0]  wave_code;
   logic [31:0] sample_total;
   logic [15:0] sample_value;
   logic        end_of_hit;

   modport source (output valid, output item_kind, output board_id, output channel_id,
                   output time_tag, output energy_long, output energy_cal_bits,
                   output energy_short_gate, output hit_flags, output wave_code,
                   output sample_total, output sample_value, output end_of_hit,
                   input ready);
   modport sink   (input valid, input item_kind, input board_id, input channel_id,
                   input time_tag, input energy_long, input energy_cal_bits,
                   input energy_short_gate, input hit_flags, input wave_code,
                   input sample_total, input sample_value, input end_of_hit,
                   output ready);
endinterface

// File: hw/rtl/dhru_csr.sv
// Configuration registers of the hit record unpacker behind an APB-style port.
// Depends on dhru_pkg.
module dhru_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [dhru_pkg::CSR_AW-1:0] paddr,
   input  logic [dhru_pkg::CSR_DW-1:0] pwdata,
   output logic [dhru_pkg::CSR_DW-1:0] prdata,
   output logic                        pready,
   output dhru_pkg::cfg_type           cfg
);

   dhru_pkg::cfg_type cfg_ff, cfg_in;
   logic              wr_en;
   logic [1:0]        reg_idx;
   logic              rd_bit;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[3:2];
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            dhru_pkg::REG_HAS_ENERGY:   cfg_in.has_energy            = pwdata[0];
            dhru_pkg::REG_HAS_ECAL:     cfg_in.has_energy_calibrated = pwdata[0];
            dhru_pkg::REG_HAS_ESHORT:   cfg_in.has_energy_short      = pwdata[0];
            dhru_pkg::REG_HAS_WAVEFORM: cfg_in.has_waveform          = pwdata[0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         dhru_pkg::REG_HAS_ENERGY:   rd_bit = cfg_ff.has_energy;
         dhru_pkg::REG_HAS_ECAL:     rd_bit = cfg_ff.has_energy_calibrated;
         dhru_pkg::REG_HAS_ESHORT:   rd_bit = cfg_ff.has_energy_short;
         dhru_pkg::REG_HAS_WAVEFORM: rd_bit = cfg_ff.has_waveform;
         default:                    rd_bit = 1'b0;
      endcase
      prdata = {{(dhru_pkg::CSR_DW-1){1'b0}}, rd_bit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: hw/rtl/dhru_unpack.sv
// Unpack datapath: input byte register, field decode and hit state, result register.
// Depends on dhru_pkg.
module dhru_unpack (
   input  logic                        clock,
   input  logic                        reset,
   input  dhru_pkg::cfg_type           cfg,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [dhru_pkg::DATA_W-1:0] in_byte,
   output logic                        out_valid,
   input  logic                        out_ready,
   output dhru_pkg::rsp_type           out_beat
);

   localparam int unsigned PW = dhru_pkg::PHASE_W;
   localparam int unsigned SW = dhru_pkg::SEG_IDX_W;

   logic                        in_valid_ff;
   logic [dhru_pkg::DATA_W-1:0] byte_ff;
   logic                        out_valid_ff, out_valid_in;
   dhru_pkg::rsp_type           out_ff, out_in;

   logic [PW-1:0] phase_ff, phase_in;
   logic [63:0]   asm_ff, asm_in;
   logic [15:0]   board_ff, board_in;
   logic [15:0]   channel_ff, channel_in;
   logic [63:0]   time_ff, time_in;
   logic [15:0]   energy_ff, energy_in;
   logic [63:0]   ecal_ff, ecal_in;
   logic [15:0]   eshort_ff, eshort_in;
   logic [31:0]   flags_ff, flags_in;
   logic [7:0]    wcode_ff, wcode_in;
   logic [31:0]   left_ff, left_in;
   logic [7:0]    lowb_ff, lowb_in;

   logic                     advance;
   logic                     fire;
   logic [dhru_pkg::NUM_SEG-1:0] seg_en;
   logic                     found;
   logic [SW-1:0]            seg_idx;
   logic [PW-1:0]            seg_start;
   logic [PW-1:0]            start_acc;
   logic [PW-1:0]            k;
   logic [PW-1:0]            phase_base;
   logic                     seg_done;
   logic                     seg_last;
   logic                     emit;
   logic                     emit_kind;
   logic                     emit_end;
   logic [15:0]              emit_sample;

   assign advance   = ~out_valid_ff | out_ready;
   assign fire      = in_valid_ff & advance;
   assign in_ready  = ~in_valid_ff | advance;
   assign out_valid = out_valid_ff;
   assign out_beat  = out_ff;

   assign seg_en = {cfg.has_waveform, cfg.has_waveform, 1'b1, cfg.has_energy_short,
                    cfg.has_energy_calibrated, cfg.has_energy, 1'b1, 1'b1, 1'b1};

   always_comb begin
      start_acc = '0;
      found     = 1'b0;
      seg_idx   = dhru_pkg::SEG_BOARD;
      seg_start = '0;
      for (int s = 0; s < dhru_pkg::NUM_SEG; s++) begin
         if (seg_en[s] && !found) begin
            if (phase_ff < start_acc + {2'b00, dhru_pkg::SEG_LEN[s]}) begin
               found     = 1'b1;
               seg_idx   = SW'(s);
               seg_start = start_acc;
            end else begin
               start_acc = start_acc + {2'b00, dhru_pkg::SEG_LEN[s]};
            end
         end
      end
   end

   assign phase_base = found ? phase_ff : '0;
   assign k          = found ? (phase_ff - seg_start) : '0;
   assign seg_done   = (k + 6'd1) == {2'b00, dhru_pkg::SEG_LEN[seg_idx]};
   assign seg_last   = (seg_idx == dhru_pkg::SEG_COUNT) ||
                       ((seg_idx == dhru_pkg::SEG_FLAGS) && !cfg.has_waveform);

   always_comb begin
      phase_in    = phase_ff;
      asm_in      = asm_ff;
      board_in    = board_ff;
      channel_in  = channel_ff;
      time_in     = time_ff;
      energy_in   = energy_ff;
      ecal_in     = ecal_ff;
      eshort_in   = eshort_ff;
      flags_in    = flags_ff;
      wcode_in    = wcode_ff;
      left_in     = left_ff;
      lowb_in     = lowb_ff;
      emit        = 1'b0;
      emit_kind   = dhru_pkg::KIND_RECORD;
      emit_end    = 1'b0;
      emit_sample = '0;
      if (fire) begin
         if (phase_ff == dhru_pkg::PH_SAMPLE_LO) begin
            lowb_in  = byte_ff;
            phase_in = dhru_pkg::PH_SAMPLE_HI;
         end else if (phase_ff == dhru_pkg::PH_SAMPLE_HI) begin
            left_in     = (left_ff != '0) ? (left_ff - 32'd1) : left_ff;
            emit        = 1'b1;
            emit_kind   = dhru_pkg::KIND_SAMPLE;
            emit_end    = (left_in == '0);
            emit_sample = {byte_ff, lowb_ff};
            phase_in    = emit_end ? '0 : dhru_pkg::PH_SAMPLE_LO;
         end else begin
            if ((seg_idx == dhru_pkg::SEG_BOARD) && (k == '0)) begin
               energy_in = '0;
               ecal_in   = '0;
               eshort_in = '0;
               wcode_in  = '0;
               left_in   = '0;
            end
            asm_in   = ((k == '0) ? 64'd0 : asm_ff) |
                       ({56'd0, byte_ff} << {k[2:0], 3'b000});
            phase_in = phase_base + 6'd1;
            if (seg_done) begin
               case (seg_idx)
                  dhru_pkg::SEG_BOARD:    board_in   = asm_in[15:0];
                  dhru_pkg::SEG_CHANNEL:  channel_in = asm_in[15:0];
                  dhru_pkg::SEG_TIME:     time_in    = asm_in;
                  dhru_pkg::SEG_ENERGY:   energy_in  = asm_in[15:0];
                  dhru_pkg::SEG_ECAL:     ecal_in    = asm_in;
                  dhru_pkg::SEG_ESHORT:   eshort_in  = asm_in[15:0];
                  dhru_pkg::SEG_FLAGS:    flags_in   = asm_in[31:0];
                  dhru_pkg::SEG_WAVECODE: wcode_in   = asm_in[7:0];
                  default:                left_in    = asm_in[31:0];
               endcase
               if (seg_last) begin
                  emit = 1'b1;
                  if ((seg_idx == dhru_pkg::SEG_COUNT) && (left_in != '0)) begin
                     phase_in = dhru_pkg::PH_SAMPLE_LO;
                     emit_end = 1'b0;
                  end else begin
                     phase_in = '0;
                     emit_end = 1'b1;
                  end
               end
            end
         end
      end
   end

   always_comb begin
      out_in.item_kind         = emit_kind;
      out_in.board_id          = board_in;
      out_in.channel_id        = channel_in;
      out_in.time_tag          = time_in;
      out_in.energy_long       = energy_in;
      out_in.energy_cal_bits   = ecal_in;
      out_in.energy_short_gate = eshort_in;
      out_in.hit_flags         = flags_in;
      out_in.wave_code         = wcode_in;
      out_in.sample_total      = left_in;
      out_in.sample_value      = emit_sample;
      out_in.end_of_hit        = emit_end;
      if (fire) begin
         out_valid_in = emit;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= '0;
         asm_ff       <= '0;
         board_ff     <= '0;
         channel_ff   <= '0;
         time_ff      <= '0;
         energy_ff    <= '0;
         ecal_ff      <= '0;
         eshort_ff    <= '0;
         flags_ff     <= '0;
         wcode_ff     <= '0;
         left_ff      <= '0;
         lowb_ff      <= '0;
      end else begin
         if (in_valid && in_ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
         asm_ff       <= asm_in;
         board_ff     <= board_in;
         channel_ff   <= channel_in;
         time_ff      <= time_in;
         energy_ff    <= energy_in;
         ecal_ff      <= ecal_in;
         eshort_ff    <= eshort_in;
         flags_ff     <= flags_in;
         wcode_ff     <= wcode_in;
         left_ff      <= left_in;
         lowb_ff      <= lowb_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         byte_ff <= in_byte;
      end
      if (fire) begin
         out_ff <= out_in;
      end
   end

endmodule

// File: hw/rtl/digitizer_hit_record_unpacker_unit.sv
// Digitizer hit record unpacker: one stream byte per beat in, record and sample beats out.
// An accepted byte passes the input byte register, then the decode stage into the result register;
// throughput 1 byte per cycle while the result register is empty or its beat is taken,
// set by the single decode stage between them. A hit yields its record beat from its last fixed byte.
// Synchronous active-high reset clears the hit state, the phase counter and all flags.
// Depends on dhru_pkg, dhru_if, dhru_csr and dhru_unpack.
module digitizer_hit_record_unpacker_unit (
   input  logic                        clock,
   input  logic                        reset,
   dhru_req_if.sink                    req,
   dhru_rsp_if.source                  rsp,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [dhru_pkg::CSR_AW-1:0] paddr,
   input  logic [dhru_pkg::CSR_DW-1:0] pwdata,
   output logic [dhru_pkg::CSR_DW-1:0] prdata,
   output logic                        pready
);

   dhru_pkg::cfg_type cfg;
   dhru_pkg::rsp_type beat;

   dhru_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   dhru_unpack u_unpack (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .in_byte   (req.data_byte),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_beat  (beat)
   );

   assign rsp.item_kind         = beat.item_kind;
   assign rsp.board_id          = beat.board_id;
   assign rsp.channel_id        = beat.channel_id;
   assign rsp.time_tag          = beat.time_tag;
   assign rsp.energy_long       = beat.energy_long;
   assign rsp.energy_cal_bits   = beat.energy_cal_bits;
   assign rsp.energy_short_gate = beat.energy_short_gate;
   assign rsp.hit_flags         = beat.hit_flags;
   assign rsp.wave_code         = beat.wave_code;
   assign rsp.sample_total      = beat.sample_total;
   assign rsp.sample_value      = beat.sample_value;
   assign rsp.end_of_hit        = beat.end_of_hit;

endmodule

// File: dv/digitizer_hit_record_unpacker_unit_test.sv
`timescale 1ns / 100ps
// Self-checking testbench of digitizer_hit_record_unpacker_unit: byte stream in, hit beats out.
// Drives hits under many register settings and checks every result beat against a local model.
// Depends on dhru_pkg, dhru_if and the unit itself.
module digitizer_hit_record_unpacker_unit_test;

   localparam int STALL_LIMIT = 4000;
   localparam int HOLD_CYCLES = 400;
   localparam int RANDOM_BYTES = 250;

   typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_style_type;

   typedef struct packed {
      logic [5:0]  phase;
      logic [63:0] gather;
      logic [15:0] board;
      logic [15:0] channel;
      logic [63:0] stamp;
      logic [15:0] energy;
      logic [63:0] ecal;
      logic [15:0] eshort;
      logic [31:0] flags;
      logic [7:0]  wcode;
      logic [31:0] left;
      logic [7:0]  low;
   } unpack_state_type;

   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [dhru_pkg::CSR_AW-1:0] paddr;
   logic [dhru_pkg::CSR_DW-1:0] pwdata;
   logic [dhru_pkg::CSR_DW-1:0] prdata;
   logic pready;

   dhru_req_if req_bus ();
   dhru_rsp_if rsp_bus ();

   digitizer_hit_record_unpacker_unit u_top (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus),
      .rsp     (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   dhru_pkg::cfg_type  cfg;
   unpack_state_type   live_st;
   unpack_state_type   plan_st;
   logic [7:0]         pending_bytes [$];
   dhru_pkg::rsp_type  expected_hits [$];
   dhru_pkg::rsp_type  drv_result;
   dhru_pkg::rsp_type  want;
   dhru_pkg::rsp_type  seen;

   int errors;
   int bytes_queued;
   int bytes_in;
   int n_records;
   int n_samples;
   int n_settings;
   int gap_left;
   int stall_left;
   int hold_left;
   int hold_tickets;
   int hold_served;
   int idle_cycles;
   bit src_quiet;
   bit snk_quiet;

   always #10 clock = ~clock;

   function automatic bit field_present(dhru_pkg::cfg_type c, int s);
      case (s)
         dhru_pkg::SEG_ENERGY:                      return c.has_energy;
         dhru_pkg::SEG_ECAL:                        return c.has_energy_calibrated;
         dhru_pkg::SEG_ESHORT:                      return c.has_energy_short;
         dhru_pkg::SEG_WAVECODE, dhru_pkg::SEG_COUNT: return c.has_waveform;
         default:                                   return 1'b1;
      endcase
   endfunction

   function automatic dhru_pkg::rsp_type hit_result(unpack_state_type st, logic kind,
                                                    logic [31:0] total, logic [15:0] sample,
                                                    logic fin);
      dhru_pkg::rsp_type r;
      r.item_kind         = kind;
      r.board_id          = st.board;
      r.channel_id        = st.channel;
      r.time_tag          = st.stamp;
      r.energy_long       = st.energy;
      r.energy_cal_bits   = st.ecal;
      r.energy_short_gate = st.eshort;
      r.hit_flags         = st.flags;
      r.wave_code         = st.wcode;
      r.sample_total      = total;
      r.sample_value      = sample;
      r.end_of_hit        = fin;
      return r;
   endfunction

   // Advance the unpacker state by one stream byte; returns 1 when a beat comes out.
   function automatic bit unpack_byte(inout unpack_state_type st,
                                      input dhru_pkg::cfg_type c,
                                      input logic [7:0] b, output dhru_pkg::rsp_type r);
      int seg;
      int start;
      int k;
      bit fin;
      bit tail;
      seg = -1;
      start = 0;
      r = '0;
      if (st.phase == dhru_pkg::PH_SAMPLE_LO) begin
         st.low = b;
         st.phase = dhru_pkg::PH_SAMPLE_HI;
         return 1'b0;
      end
      if (st.phase == dhru_pkg::PH_SAMPLE_HI) begin
         if (st.left != 0) st.left = st.left - 1;
         fin = (st.left == 0);
         st.phase = fin ? 6'd0 : dhru_pkg::PH_SAMPLE_LO;
         r = hit_result(st, dhru_pkg::KIND_SAMPLE, st.left, {b, st.low}, fin);
         return 1'b1;
      end
      for (int s = 0; s < dhru_pkg::NUM_SEG; s++) begin
         if (seg < 0 && field_present(c, s)) begin
            if (int'(st.phase) < start + int'(dhru_pkg::SEG_LEN[s])) seg = s;
            else start = start + int'(dhru_pkg::SEG_LEN[s]);
         end
      end
      // phase past the last fixed field: restart as a new hit
      if (seg < 0) begin
         st.phase = '0;
         seg = 0;
         start = 0;
      end
      k = int'(st.phase) - start;
      if (seg == dhru_pkg::SEG_BOARD && k == 0) begin
         st.energy = '0;
         st.ecal   = '0;
         st.eshort = '0;
         st.wcode  = '0;
         st.left   = '0;
      end
      if (k == 0) st.gather = '0;
      st.gather = st.gather | ({56'h0, b} << (8 * (k % 8)));
      st.phase = st.phase + 6'd1;
      if (k + 1 != int'(dhru_pkg::SEG_LEN[seg])) return 1'b0;
      case (seg)
         dhru_pkg::SEG_BOARD:    st.board   = st.gather[15:0];
         dhru_pkg::SEG_CHANNEL:  st.channel = st.gather[15:0];
         dhru_pkg::SEG_TIME:     st.stamp   = st.gather;
         dhru_pkg::SEG_ENERGY:   st.energy  = st.gather[15:0];
         dhru_pkg::SEG_ECAL:     st.ecal    = st.gather;
         dhru_pkg::SEG_ESHORT:   st.eshort  = st.gather[15:0];
         dhru_pkg::SEG_FLAGS:    st.flags   = st.gather[31:0];
         dhru_pkg::SEG_WAVECODE: st.wcode   = st.gather[7:0];
         default:                st.left    = st.gather[31:0];
      endcase
      tail = 1'b1;
      for (int t = seg + 1; t < dhru_pkg::NUM_SEG; t++) begin
         if (field_present(c, t)) tail = 1'b0;
      end
      if (!tail) return 1'b0;
      if (seg == dhru_pkg::SEG_COUNT && st.left != 0) begin
         st.phase = dhru_pkg::PH_SAMPLE_LO;
         r = hit_result(st, dhru_pkg::KIND_RECORD, st.left, 16'h0, 1'b0);
      end else begin
         st.phase = '0;
         r = hit_result(st, dhru_pkg::KIND_RECORD, st.left, 16'h0, 1'b1);
      end
      return 1'b1;
   endfunction

   function automatic int pick_gap(bit quiet);
      int unsigned r;
      r = $urandom_range(99);
      if (quiet || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [63:0] pick_value(fill_style_type style);
      int unsigned r;
      r = $urandom_range(7);
      if (style == FILL_ZERO) return '0;
      if (style == FILL_ONES) return '1;
      if (r == 0) return '0;
      if (r == 1) return '1;
      return {$urandom, $urandom};
   endfunction

   function automatic int pick_samples();
      int unsigned r;
      r = $urandom_range(9);
      if (r < 6) return $urandom_range(0, 4);
      if (r < 9) return $urandom_range(5, 12);
      return $urandom_range(13, 24);
   endfunction

   task automatic check_field(input string name, input logic [63:0] exp_v,
                              input logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_v, act_v);
         errors++;
      end
   endtask

   task automatic queue_byte(input logic [7:0] b);
      dhru_pkg::rsp_type scratch;
      pending_bytes.push_back(b);
      void'(unpack_byte(plan_st, cfg, b, scratch));
      bytes_queued++;
   endtask

   task automatic put_field(input logic [63:0] v, input int nbytes, inout int sent,
                            input int cut);
      for (int i = 0; i < nbytes; i++) begin
         if (cut < 0 || sent < cut) queue_byte(v[8*i +: 8]);
         sent++;
      end
   endtask

   // Queue one hit in the current layout; stop after cut bytes when cut is not negative.
   task automatic send_hit(input logic [31:0] count, input int nsamp, input int cut,
                           input fill_style_type style);
      int sent;
      sent = 0;
      put_field(pick_value(style), 2, sent, cut);
      put_field(pick_value(style), 2, sent, cut);
      put_field(pick_value(style), 8, sent, cut);
      if (cfg.has_energy) put_field(pick_value(style), 2, sent, cut);
      if (cfg.has_energy_calibrated) put_field(pick_value(style), 8, sent, cut);
      if (cfg.has_energy_short) put_field(pick_value(style), 2, sent, cut);
      put_field(pick_value(style), 4, sent, cut);
      if (cfg.has_waveform) begin
         put_field(pick_value(style), 1, sent, cut);
         put_field({32'h0, count}, 4, sent, cut);
         for (int i = 0; i < nsamp; i++) put_field(pick_value(style), 2, sent, cut);
      end
   endtask

   // Pad the stream back to a record boundary; zero bytes keep any sample count small.
   task automatic fill_to_start();
      while (plan_st.phase != 0)
         queue_byte(cfg.has_waveform ? 8'h00 : 8'($urandom_range(255)));
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_bytes.size() != 0 || req_bus.valid || expected_hits.size() != 0);
      repeat (6) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic v);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {31'h0, v};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      pwrite  <= 1'b0;
      penable <= 1'b0;
      case (idx)
         dhru_pkg::REG_HAS_ENERGY: cfg.has_energy            = v;
         dhru_pkg::REG_HAS_ECAL:   cfg.has_energy_calibrated = v;
         dhru_pkg::REG_HAS_ESHORT: cfg.has_energy_short      = v;
         default:                  cfg.has_waveform          = v;
      endcase
      // read back
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      check_field("register readback", {32'h0, 31'h0, v}, {32'h0, prdata});
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic write_config(input dhru_pkg::cfg_type next);
      csr_write(dhru_pkg::REG_HAS_ENERGY, next.has_energy);
      csr_write(dhru_pkg::REG_HAS_ECAL, next.has_energy_calibrated);
      csr_write(dhru_pkg::REG_HAS_ESHORT, next.has_energy_short);
      csr_write(dhru_pkg::REG_HAS_WAVEFORM, next.has_waveform);
      n_settings++;
   endtask

   // driver: hold a beat until taken, then advance after a random gap
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            bytes_in++;
            if (unpack_byte(live_st, cfg, req_bus.data_byte, drv_result))
               expected_hits.push_back(drv_result);
         end
         if (!(req_bus.valid && !req_bus.ready)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_bus.valid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
               req_bus.valid     <= 1'b1;
               req_bus.data_byte <= pending_bytes.pop_front();
               gap_left = pick_gap(src_quiet);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each result beat, then drive ready with stalls and long holds
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen = {rsp_bus.item_kind, rsp_bus.board_id, rsp_bus.channel_id, rsp_bus.time_tag,
                    rsp_bus.energy_long, rsp_bus.energy_cal_bits, rsp_bus.energy_short_gate,
                    rsp_bus.hit_flags, rsp_bus.wave_code, rsp_bus.sample_total,
                    rsp_bus.sample_value, rsp_bus.end_of_hit};
            if (seen.item_kind == dhru_pkg::KIND_SAMPLE) n_samples++;
            else n_records++;
            if (expected_hits.size() == 0) begin
               $display("%0t unexpected beat: expected none actual %0h", $time, seen);
               errors++;
            end else begin
               want = expected_hits.pop_front();
               check_field("item_kind", want.item_kind, seen.item_kind);
               check_field("board_id", want.board_id, seen.board_id);
               check_field("channel_id", want.channel_id, seen.channel_id);
               check_field("time_tag", want.time_tag, seen.time_tag);
               check_field("energy_long", want.energy_long, seen.energy_long);
               check_field("energy_cal_bits", want.energy_cal_bits, seen.energy_cal_bits);
               check_field("energy_short_gate", want.energy_short_gate,
                           seen.energy_short_gate);
               check_field("hit_flags", want.hit_flags, seen.hit_flags);
               check_field("wave_code", want.wave_code, seen.wave_code);
               check_field("sample_total", want.sample_total, seen.sample_total);
               check_field("sample_value", want.sample_value, seen.sample_value);
               check_field("end_of_hit", want.end_of_hit, seen.end_of_hit);
            end
         end
         if (hold_tickets != hold_served) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            stall_left = pick_gap(snk_quiet);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || psel || reset)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t no beat moved for %0d cycles", $time, STALL_LIMIT);
         $display("digitizer_hit_record_unpacker_unit_test: FAIL");
         $finish;
      end
   end

   initial begin
      dhru_pkg::cfg_type next_cfg;
      int phase_no;
      int rnd_start;
      int n;
      int unsigned r;
      clock = 1'b0;
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.data_byte = '0;
      rsp_bus.ready = 1'b0;
      cfg = '0;
      live_st = '0;
      plan_st = '0;
      errors = 0;
      bytes_queued = 0;
      bytes_in = 0;
      n_records = 0;
      n_samples = 0;
      n_settings = 0;
      gap_left = 0;
      stall_left = 0;
      hold_left = 0;
      hold_tickets = 0;
      hold_served = 0;
      idle_cycles = 0;
      src_quiet = 1'b0;
      snk_quiet = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, zero samples, layout changes mid-hit and during samples
      write_config('0);
      send_hit(0, 0, -1, FILL_ONES);
      send_hit(0, 0, -1, FILL_ZERO);
      wait_idle();
      write_config('1);
      send_hit(2, 2, -1, FILL_ONES);
      send_hit(0, 0, -1, FILL_ZERO);
      send_hit(3, 3, -1, FILL_RANDOM);
      wait_idle();
      send_hit(2, 2, 20, FILL_RANDOM);
      wait_idle();
      write_config('0);
      fill_to_start();
      wait_idle();
      send_hit(0, 0, 8, FILL_RANDOM);
      wait_idle();
      write_config('1);
      fill_to_start();
      wait_idle();
      send_hit(4, 4, 36, FILL_RANDOM);
      wait_idle();
      write_config(dhru_pkg::cfg_type'(4'b1000));
      fill_to_start();
      send_hit(0, 0, -1, FILL_RANDOM);
      wait_idle();

      // random: mostly well-formed hits, some truncated hits and raw noise
      phase_no = 0;
      rnd_start = bytes_queued;
      while (phase_no < 2 || bytes_queued - rnd_start < RANDOM_BYTES) begin
         if (phase_no == 0) next_cfg = '1;
         else if (phase_no == 1) next_cfg = '0;
         else next_cfg = dhru_pkg::cfg_type'($urandom_range(15));
         if (phase_no == 2) next_cfg.has_waveform = 1'b1;
         write_config(next_cfg);
         src_quiet = ($urandom_range(3) == 0);
         snk_quiet = ($urandom_range(3) == 0);
         if (phase_no == 1) begin
            hold_tickets++;
            send_hit(24, 24, -1, FILL_RANDOM);
         end
         n = $urandom_range(2, 4);
         repeat (n) begin
            r = $urandom_range(9);
            if (r == 7) begin
               send_hit(2, 2, $urandom_range(1, 15), FILL_RANDOM);
               if (cfg.has_waveform) fill_to_start();
            end else if (r >= 8 && !cfg.has_waveform) begin
               repeat ($urandom_range(8, 40)) queue_byte(8'($urandom_range(255)));
            end else begin
               r = pick_samples();
               send_hit(r, r, -1, FILL_RANDOM);
            end
         end
         fill_to_start();
         wait_idle();
         phase_no++;
      end

      // a hit whose sample count is the largest, left running at the end
      next_cfg = dhru_pkg::cfg_type'($urandom_range(15));
      next_cfg.has_waveform = 1'b1;
      write_config(next_cfg);
      send_hit(32'hFFFF_FFFF, 3, -1, FILL_RANDOM);
      do @(posedge clock);
      while (pending_bytes.size() != 0 || req_bus.valid || expected_hits.size() != 0);
      repeat (8) @(posedge clock);

      $display("Checked %0d stream bytes over %0d register settings: %0d record and %0d sample beats",
               bytes_in, n_settings, n_records, n_samples);
      if (errors == 0 && expected_hits.size() == 0)
         $display("digitizer_hit_record_unpacker_unit_test: PASS");
      else
         $display("digitizer_hit_record_unpacker_unit_test: FAIL");
      $finish;
   end

endmodule
